// File: design/aarm_pkg.sv
`default_nettype none

package aarm_pkg;

  typedef struct packed {
    logic signed [23:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] elem0;
    logic signed [15:0] elem1;
    logic signed [15:0] elem2;
    logic signed [15:0] elem3;
    logic               last_row;
    logic               axis_error;
  } out_t;

  // normalized axis info carried along the square root chain
  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       sgn;
    logic             err;
    logic [4:0]       m;
  } axis_info_t;

  typedef struct packed {
    axis_info_t         info;
    logic signed [31:0] z0;
    logic               flip;
  } sq_side_t;

  typedef struct packed {
    logic [2:0]         sgn;
    logic               err;
    logic signed [31:0] z0;
    logic               flip;
  } dv_side_t;

  typedef struct packed {
    logic [2:0][31:0] u;
    logic             err;
    logic             flip;
  } cd_side_t;

  localparam int SQ_SIDE_W = $bits(sq_side_t);
  localparam int DV_SIDE_W = $bits(dv_side_t);
  localparam int CD_SIDE_W = $bits(cd_side_t);

  localparam int SQ_N_W   = 62;
  localparam int SQ_RES_W = 63;
  localparam int SQ_STEPS = 31;
  localparam int DIV_W    = 31;
  localparam int DIV_STEPS = 31;
  localparam int LANES    = 3;
  localparam int CORD_W   = 34;
  localparam int ATAN_N   = 24;

  localparam logic [24:0] ANG_BIAS    = 25'd8432640;  // 183 full turns
  localparam logic [24:0] TURN_UNITS  = 25'd46080;
  localparam logic [14:0] RECIP_TURN  = 15'd23302;    // ceil(2^20/45)
  localparam logic [38:0] RECIP_45    = 39'd390937467654; // ceil(2^44/45)
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;
  localparam logic [1:0] ROW_LAST = 2'd3;

  localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  function automatic logic [15:0] abs16(input logic signed [15:0] a);
    return a[15] ? 16'(-a) : 16'(a);
  endfunction

  // Q30 -> Q2.14, round half up, saturate
  function automatic logic signed [15:0] sat_q14(input logic signed [36:0] v);
    logic signed [37:0] rnd;
    logic signed [21:0] sh;
    rnd = 38'(v) + 38'sd32768;
    sh  = 22'(rnd >>> 16);
    if (sh > 22'sd32767) begin
      return 16'sd32767;
    end else if (sh < -22'sd32768) begin
      return -16'sd32768;
    end else begin
      return 16'(sh);
    end
  endfunction

endpackage

`default_nettype wire

// File: design/aarm_sqrt_cell.sv
`default_nettype none

// one restoring step of the integer square root
module aarm_sqrt_cell #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             v_i,
  input  wire logic [aarm_pkg::SQ_N_W-1:0]      n_i,
  input  wire logic [aarm_pkg::SQ_RES_W-1:0]    res_i,
  input  wire logic [SIDE_W-1:0]                side_i,
  output logic                                  v_o,
  output logic [aarm_pkg::SQ_N_W-1:0]           n_o,
  output logic [aarm_pkg::SQ_RES_W-1:0]         res_o,
  output logic [SIDE_W-1:0]                     side_o
);

  localparam logic [aarm_pkg::SQ_RES_W-1:0] BIT = aarm_pkg::SQ_RES_W'(1) << SHIFT;

  logic                              v_r;
  logic [aarm_pkg::SQ_N_W-1:0]       n_r, n_nxt;
  logic [aarm_pkg::SQ_RES_W-1:0]     res_r, res_nxt;
  logic [SIDE_W-1:0]                 side_r;
  logic [aarm_pkg::SQ_RES_W-1:0]     trial;

  always_comb begin
    trial = res_i + BIT;
    if ({1'b0, n_i} >= trial) begin
      n_nxt   = aarm_pkg::SQ_N_W'({1'b0, n_i} - trial);
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      n_nxt   = n_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      res_r  <= res_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign n_o    = n_r;
  assign res_o  = res_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// File: design/aarm_div_cell.sv
`default_nettype none

// one quotient bit of the three axis divisions by the root
module aarm_div_cell #(
  parameter int SIDE_W = 1
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic                                              en,
  input  wire logic                                              v_i,
  input  wire logic [aarm_pkg::LANES-1:0][aarm_pkg::DIV_W-1:0]   rem_i,
  input  wire logic [aarm_pkg::LANES-1:0]                        bit_i,
  input  wire logic [aarm_pkg::LANES-1:0][aarm_pkg::DIV_W-1:0]   quo_i,
  input  wire logic [aarm_pkg::DIV_W-1:0]                        den_i,
  input  wire logic [SIDE_W-1:0]                                 side_i,
  output logic                                                   v_o,
  output logic [aarm_pkg::LANES-1:0][aarm_pkg::DIV_W-1:0]        rem_o,
  output logic [aarm_pkg::LANES-1:0][aarm_pkg::DIV_W-1:0]        quo_o,
  output logic [aarm_pkg::DIV_W-1:0]                             den_o,
  output logic [SIDE_W-1:0]                                      side_o
);

  logic                                             v_r;
  logic [aarm_pkg::LANES-1:0][aarm_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [aarm_pkg::LANES-1:0][aarm_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [aarm_pkg::DIV_W-1:0]                       den_r;
  logic [SIDE_W-1:0]                                side_r;
  logic [aarm_pkg::DIV_W:0]                         trial;
  logic                                             ge;

  always_comb begin
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    trial   = '0;
    ge      = 1'b0;
    for (int k = 0; k < aarm_pkg::LANES; k++) begin
      trial = {rem_i[k], bit_i[k]};
      ge    = trial >= {1'b0, den_i};
      rem_nxt[k] = ge ? aarm_pkg::DIV_W'(trial - {1'b0, den_i})
                      : trial[aarm_pkg::DIV_W-1:0];
      quo_nxt[k] = {quo_i[k][aarm_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// File: design/aarm_cordic_cell.sv
`default_nettype none

// one CORDIC rotation stage, direction from the sign of z
module aarm_cordic_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   v_i,
  input  wire logic signed [aarm_pkg::CORD_W-1:0]     x_i,
  input  wire logic signed [aarm_pkg::CORD_W-1:0]     y_i,
  input  wire logic signed [aarm_pkg::CORD_W-1:0]     z_i,
  input  wire logic [SIDE_W-1:0]                      side_i,
  output logic                                        v_o,
  output logic signed [aarm_pkg::CORD_W-1:0]          x_o,
  output logic signed [aarm_pkg::CORD_W-1:0]          y_o,
  output logic signed [aarm_pkg::CORD_W-1:0]          z_o,
  output logic [SIDE_W-1:0]                           side_o
);

  localparam logic signed [aarm_pkg::CORD_W-1:0] ATAN =
    $signed(aarm_pkg::CORD_W'(aarm_pkg::ATAN_TURNS[IDX]));

  logic                                  v_r;
  logic signed [aarm_pkg::CORD_W-1:0]    x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [aarm_pkg::CORD_W-1:0]    dx, dy;
  logic [SIDE_W-1:0]                     side_r;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[aarm_pkg::CORD_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// File: design/axis_angle_rotation_matrix_top.sv
`default_nettype none

// Port     Dir  Handshake             Payload
// in_      in   in_valid / in_ready   aarm_pkg::in_t  angle, axis_x, axis_y, axis_z
// out_     out  out_valid / out_ready aarm_pkg::out_t one matrix row per transfer
//
// Every request gives four rows on out_, one per cycle while out_ready is high, so
// the row serializer limits how often a new request is taken.
// Reset clears the valid bits of the chain and the serializer's busy flag and row, nothing else.
// While the serializer is busy and a finished matrix waits, the whole chain holds.

module axis_angle_rotation_matrix_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire aarm_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output aarm_pkg::out_t       out_data
);

  localparam int NS = aarm_pkg::SQ_STEPS;
  localparam int ND = aarm_pkg::DIV_STEPS;
  localparam int NL = aarm_pkg::LANES;
  localparam int CW = aarm_pkg::CORD_W;
  localparam int DW = aarm_pkg::DIV_W;
  // pair products: xx yy zz xy xz yz
  localparam int PAIR_A [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};

  logic en;
  logic ser_load;

  // input register
  logic          a_v_r;
  aarm_pkg::in_t a_d_r;

  // squares, magnitudes, angle bias and turn estimate
  logic                 b_v_r;
  logic [31:0]          b_s_r, b_s_nxt;
  logic [NL-1:0][15:0]  b_mag_r, b_mag_nxt;
  logic [NL-1:0]        b_sgn_r, b_sgn_nxt;
  logic [24:0]          b_angu_r, b_angu_nxt;
  logic [29:0]          b_qp_r, b_qp_nxt;
  logic signed [31:0]   sqx, sqy, sqz;

  // normalizing shift, angle remainder
  logic                 c_v_r;
  aarm_pkg::axis_info_t c_info_r, c_info_nxt;
  logic [61:0]          c_n_r, c_n_nxt;
  logic [15:0]          c_r_r, c_r_nxt;
  logic [4:0]           msb;

  // phase product
  logic                 d_v_r;
  aarm_pkg::axis_info_t d_info_r;
  logic [61:0]          d_n_r;
  logic [54:0]          d_pp_r;

  // phase and quadrant fold
  logic                 e_v_r;
  aarm_pkg::sq_side_t   e_side_r, e_side_nxt;
  logic [61:0]          e_n_r;
  logic [31:0]          ph;

  // square root chain
  logic                                  sq_v    [NS+1];
  logic [aarm_pkg::SQ_N_W-1:0]           sq_n    [NS+1];
  logic [aarm_pkg::SQ_RES_W-1:0]         sq_res  [NS+1];
  logic [aarm_pkg::SQ_SIDE_W-1:0]        sq_side [NS+1];

  // division setup
  aarm_pkg::sq_side_t   sq_end;
  logic                 f_v_r;
  logic [NL-1:0][DW-1:0] f_rem_r, f_rem_nxt;
  logic [NL-1:0]        f_bit_r, f_bit_nxt;
  logic [DW-1:0]        f_den_r;
  aarm_pkg::dv_side_t   f_side_r, f_side_nxt;
  logic [46:0]          shv;

  // division chain
  logic                          dv_v    [ND+1];
  logic [NL-1:0][DW-1:0]         dv_rem  [ND+1];
  logic [NL-1:0][DW-1:0]         dv_quo  [ND+1];
  logic [DW-1:0]                 dv_den  [ND+1];
  logic [aarm_pkg::DV_SIDE_W-1:0] dv_side [ND+1];

  // CORDIC chain
  aarm_pkg::dv_side_t   dv_end;
  aarm_pkg::cd_side_t   cd_first;
  logic                            cd_v    [CORDIC_STAGES+1];
  logic signed [CW-1:0]            cd_x    [CORDIC_STAGES+1];
  logic signed [CW-1:0]            cd_y    [CORDIC_STAGES+1];
  logic signed [CW-1:0]            cd_z    [CORDIC_STAGES+1];
  logic [aarm_pkg::CD_SIDE_W-1:0]  cd_side [CORDIC_STAGES+1];

  // products
  aarm_pkg::cd_side_t   cd_end;
  logic signed [CW-1:0] cc, ss;
  logic signed [31:0]   uu [NL];
  logic signed [63:0]   ppr;
  logic signed [65:0]   spr;
  logic                 p1_v_r;
  logic signed [33:0]   p1_pair_r [6];
  logic signed [33:0]   p1_pair_nxt [6];
  logic signed [33:0]   p1_sin_r [NL];
  logic signed [33:0]   p1_sin_nxt [NL];
  logic signed [34:0]   p1_t_r, p1_t_nxt;
  logic signed [CW-1:0] p1_c_r;
  logic                 p1_err_r;

  logic                 p2_v_r;
  logic signed [68:0]   wpr;
  logic signed [35:0]   p2_w_r [6];
  logic signed [35:0]   p2_w_nxt [6];
  logic signed [33:0]   p2_sin_r [NL];
  logic signed [CW-1:0] p2_c_r;
  logic                 p2_err_r;

  logic                 p3_v_r;
  logic signed [15:0]   p3_m_r [9];
  logic signed [15:0]   p3_m_nxt [9];
  logic                 p3_err_r;

  // row serializer
  logic                 ser_busy_r;
  logic [1:0]           ser_row_r;
  logic signed [15:0]   ser_m_r [9];
  logic                 ser_err_r;

  assign ser_load = !ser_busy_r || (out_ready && ser_row_r == aarm_pkg::ROW_LAST);
  assign en       = !p3_v_r || ser_load;
  assign in_ready = en;

  // ---------------- input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r <= in_data;
    end
  end

  // ---------------- squares and angle
  always_comb begin
    sqx = a_d_r.axis_x * a_d_r.axis_x;
    sqy = a_d_r.axis_y * a_d_r.axis_y;
    sqz = a_d_r.axis_z * a_d_r.axis_z;
    b_s_nxt = 32'(sqx) + 32'(sqy) + 32'(sqz);
    b_mag_nxt[0] = aarm_pkg::abs16(a_d_r.axis_x);
    b_mag_nxt[1] = aarm_pkg::abs16(a_d_r.axis_y);
    b_mag_nxt[2] = aarm_pkg::abs16(a_d_r.axis_z);
    b_sgn_nxt = {a_d_r.axis_z[15], a_d_r.axis_y[15], a_d_r.axis_x[15]};
    // bias makes the angle positive without changing it modulo a turn
    b_angu_nxt = {a_d_r.angle[23], a_d_r.angle} + aarm_pkg::ANG_BIAS;
    b_qp_nxt   = 30'(b_angu_nxt[24:10]) * 30'(aarm_pkg::RECIP_TURN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s_r    <= b_s_nxt;
      b_mag_r  <= b_mag_nxt;
      b_sgn_r  <= b_sgn_nxt;
      b_angu_r <= b_angu_nxt;
      b_qp_r   <= b_qp_nxt;
    end
  end

  // ---------------- normalizing shift, angle remainder
  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (b_s_r[i]) begin
        msb = 5'(i);
      end
    end
    c_info_nxt.mag = b_mag_r;
    c_info_nxt.sgn = b_sgn_r;
    c_info_nxt.err = (b_s_r == 32'd0);
    // largest m with S * 4^m below 2^62
    c_info_nxt.m   = 5'((6'd61 - {1'b0, msb}) >> 1);
    c_n_nxt        = 62'(b_s_r) << {c_info_nxt.m, 1'b0};
    c_r_nxt        = 16'(b_angu_r - 25'(b_qp_r[29:20]) * aarm_pkg::TURN_UNITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_info_r <= c_info_nxt;
      c_n_r    <= c_n_nxt;
      c_r_r    <= c_r_nxt;
    end
  end

  // ---------------- phase = r * 2^32 / 46080
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_info_r <= c_info_r;
      d_n_r    <= c_n_r;
      d_pp_r   <= 55'(c_r_r) * 55'(aarm_pkg::RECIP_45);
    end
  end

  // ---------------- fold second and third quadrant
  always_comb begin
    ph               = d_pp_r[53:22];
    e_side_nxt.info  = d_info_r;
    e_side_nxt.flip  = ph[31] ^ ph[30];
    e_side_nxt.z0    = e_side_nxt.flip ? $signed({~ph[31], ph[30:0]}) : $signed(ph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= e_side_nxt;
      e_n_r    <= d_n_r;
    end
  end

  // ---------------- square root chain
  assign sq_v[0]    = e_v_r;
  assign sq_n[0]    = e_n_r;
  assign sq_res[0]  = '0;
  assign sq_side[0] = e_side_r;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    aarm_sqrt_cell #(
      .SHIFT  (2 * (NS - 1 - k)),
      .SIDE_W (aarm_pkg::SQ_SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[k]),
      .n_i    (sq_n[k]),
      .res_i  (sq_res[k]),
      .side_i (sq_side[k]),
      .v_o    (sq_v[k+1]),
      .n_o    (sq_n[k+1]),
      .res_o  (sq_res[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // ---------------- division setup: dividend is mag << (m + 30), 31 quotient bits
  always_comb begin
    sq_end = aarm_pkg::sq_side_t'(sq_side[NS]);
    shv    = '0;
    for (int k = 0; k < NL; k++) begin
      shv          = 47'(sq_end.info.mag[k]) << sq_end.info.m;
      f_rem_nxt[k] = shv[31:1];
      f_bit_nxt[k] = shv[0];
    end
    f_side_nxt.sgn  = sq_end.info.sgn;
    f_side_nxt.err  = sq_end.info.err;
    f_side_nxt.z0   = sq_end.z0;
    f_side_nxt.flip = sq_end.flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= sq_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_rem_r  <= f_rem_nxt;
      f_bit_r  <= f_bit_nxt;
      f_den_r  <= sq_res[NS][DW-1:0];
      f_side_r <= f_side_nxt;
    end
  end

  // ---------------- division chain
  assign dv_v[0]    = f_v_r;
  assign dv_rem[0]  = f_rem_r;
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = f_den_r;
  assign dv_side[0] = f_side_r;

  for (genvar j = 0; j < ND; j++) begin : g_div
    aarm_div_cell #(
      .SIDE_W (aarm_pkg::DV_SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[j]),
      .rem_i  (dv_rem[j]),
      .bit_i  ((j == 0) ? f_bit_r : {NL{1'b0}}),
      .quo_i  (dv_quo[j]),
      .den_i  (dv_den[j]),
      .side_i (dv_side[j]),
      .v_o    (dv_v[j+1]),
      .rem_o  (dv_rem[j+1]),
      .quo_o  (dv_quo[j+1]),
      .den_o  (dv_den[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // ---------------- CORDIC chain
  always_comb begin
    dv_end = aarm_pkg::dv_side_t'(dv_side[ND]);
    for (int k = 0; k < NL; k++) begin
      cd_first.u[k] = dv_end.sgn[k] ? 32'(-{1'b0, dv_quo[ND][k]})
                                    : 32'({1'b0, dv_quo[ND][k]});
    end
    cd_first.err  = dv_end.err;
    cd_first.flip = dv_end.flip;
  end

  assign cd_v[0]    = dv_v[ND];
  assign cd_x[0]    = aarm_pkg::CORDIC_GAIN;
  assign cd_y[0]    = '0;
  assign cd_z[0]    = CW'(dv_end.z0);
  assign cd_side[0] = cd_first;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    aarm_cordic_cell #(
      .IDX    (g),
      .SIDE_W (aarm_pkg::CD_SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (cd_v[g]),
      .x_i    (cd_x[g]),
      .y_i    (cd_y[g]),
      .z_i    (cd_z[g]),
      .side_i (cd_side[g]),
      .v_o    (cd_v[g+1]),
      .x_o    (cd_x[g+1]),
      .y_o    (cd_y[g+1]),
      .z_o    (cd_z[g+1]),
      .side_o (cd_side[g+1])
    );
  end

  // ---------------- first products: ai*aj, ak*s, t
  always_comb begin
    cd_end = aarm_pkg::cd_side_t'(cd_side[CORDIC_STAGES]);
    cc = cd_end.flip ? -cd_x[CORDIC_STAGES] : cd_x[CORDIC_STAGES];
    ss = cd_end.flip ? -cd_y[CORDIC_STAGES] : cd_y[CORDIC_STAGES];
    for (int k = 0; k < NL; k++) begin
      uu[k] = $signed(cd_end.u[k]);
    end
    ppr = '0;
    spr = '0;
    for (int k = 0; k < 6; k++) begin
      ppr            = uu[PAIR_A[k]] * uu[PAIR_B[k]];
      p1_pair_nxt[k] = 34'(ppr >>> 30);
    end
    for (int k = 0; k < NL; k++) begin
      spr           = uu[k] * ss;
      p1_sin_nxt[k] = 34'(spr >>> 30);
    end
    p1_t_nxt = aarm_pkg::Q30_ONE - 35'(cc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= cd_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pair_r <= p1_pair_nxt;
      p1_sin_r  <= p1_sin_nxt;
      p1_t_r    <= p1_t_nxt;
      p1_c_r    <= cc;
      p1_err_r  <= cd_end.err;
    end
  end

  // ---------------- weighted pair terms
  always_comb begin
    wpr = '0;
    for (int k = 0; k < 6; k++) begin
      wpr         = p1_pair_r[k] * p1_t_r;
      p2_w_nxt[k] = 36'(wpr >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_w_r   <= p2_w_nxt;
      p2_sin_r <= p1_sin_r;
      p2_c_r   <= p1_c_r;
      p2_err_r <= p1_err_r;
    end
  end

  // ---------------- sums, rounding, saturation; zero axis gives identity
  always_comb begin
    p3_m_nxt[0] = aarm_pkg::sat_q14(37'(p2_w_r[0]) + 37'(p2_c_r));
    p3_m_nxt[1] = aarm_pkg::sat_q14(37'(p2_w_r[3]) - 37'(p2_sin_r[2]));
    p3_m_nxt[2] = aarm_pkg::sat_q14(37'(p2_w_r[4]) + 37'(p2_sin_r[1]));
    p3_m_nxt[3] = aarm_pkg::sat_q14(37'(p2_w_r[3]) + 37'(p2_sin_r[2]));
    p3_m_nxt[4] = aarm_pkg::sat_q14(37'(p2_w_r[1]) + 37'(p2_c_r));
    p3_m_nxt[5] = aarm_pkg::sat_q14(37'(p2_w_r[5]) - 37'(p2_sin_r[0]));
    p3_m_nxt[6] = aarm_pkg::sat_q14(37'(p2_w_r[4]) - 37'(p2_sin_r[1]));
    p3_m_nxt[7] = aarm_pkg::sat_q14(37'(p2_w_r[5]) + 37'(p2_sin_r[0]));
    p3_m_nxt[8] = aarm_pkg::sat_q14(37'(p2_w_r[2]) + 37'(p2_c_r));
    if (p2_err_r) begin
      for (int k = 0; k < 9; k++) begin
        p3_m_nxt[k] = (k == 0 || k == 4 || k == 8) ? aarm_pkg::Q14_ONE : 16'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_m_r   <= p3_m_nxt;
      p3_err_r <= p2_err_r;
    end
  end

  // ---------------- row serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_busy_r <= 1'b0;
      ser_row_r  <= 2'd0;
    end else if (ser_load) begin
      ser_busy_r <= p3_v_r;
      ser_row_r  <= 2'd0;
    end else if (out_ready) begin
      ser_row_r  <= ser_row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_m_r   <= p3_m_r;
      ser_err_r <= p3_err_r;
    end
  end

  always_comb begin
    out_data.row_index  = ser_row_r;
    out_data.last_row   = (ser_row_r == aarm_pkg::ROW_LAST);
    out_data.axis_error = ser_err_r;
    case (ser_row_r)
      2'd0: begin
        out_data.elem0 = ser_m_r[0];
        out_data.elem1 = ser_m_r[1];
        out_data.elem2 = ser_m_r[2];
        out_data.elem3 = 16'sd0;
      end
      2'd1: begin
        out_data.elem0 = ser_m_r[3];
        out_data.elem1 = ser_m_r[4];
        out_data.elem2 = ser_m_r[5];
        out_data.elem3 = 16'sd0;
      end
      2'd2: begin
        out_data.elem0 = ser_m_r[6];
        out_data.elem1 = ser_m_r[7];
        out_data.elem2 = ser_m_r[8];
        out_data.elem3 = 16'sd0;
      end
      default: begin
        out_data.elem0 = 16'sd0;
        out_data.elem1 = 16'sd0;
        out_data.elem2 = 16'sd0;
        out_data.elem3 = aarm_pkg::Q14_ONE;
      end
    endcase
  end

  assign out_valid = ser_busy_r;

  // ---------------- checks
  a_stall_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with idle serializer");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.row_index != aarm_pkg::ROW_LAST |=>
      out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");

  a_err_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.axis_error && out_data.row_index == 2'd0 |->
      out_data.elem0 == aarm_pkg::Q14_ONE && out_data.elem1 == 16'sd0 &&
      out_data.elem2 == 16'sd0)
    else $error("zero axis row 0 not identity");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_row |-> out_data.elem3 == aarm_pkg::Q14_ONE &&
      out_data.elem0 == 16'sd0)
    else $error("bad homogeneous row");

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGE = 16;
  localparam int LAT = 72 + NSTAGE;
  localparam longint K_GAIN = 652032874;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint ATAN_T [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  aarm_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aarm_pkg::out_t out_data;

  axis_angle_rotation_matrix_top #(.CORDIC_STAGES(NSTAGE)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  aarm_pkg::in_t  pending_reqs[$];
  aarm_pkg::out_t expected_rows[$];
  int   mismatches = 0;
  int   rows_seen = 0;
  int   reqs_sent = 0;
  int   zero_axis_reqs = 0;
  bit   stim_done = 0;
  bit   hold_off = 1'b0;

  // floor shift for signed values
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] q30_to_q14(longint v);
    longint r;
    r = asr(v + (64'sd1 << 15), 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint unit_q30(longint a, int m, longint root);
    longint unsigned mag, q;
    mag = (a < 0) ? -a : a;
    q = (mag << (m + 30)) / longint'(root);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_rotation(aarm_pkg::in_t rq);
    longint ax, ay, az, ang, r, x, y, z, dx, dy, c, s, t, root;
    longint ux, uy, uz;
    longint unsigned sq, p;
    longint mtx[3][3];
    int m;
    bit flip;
    aarm_pkg::out_t row;
    ax = rq.axis_x; ay = rq.axis_y; az = rq.axis_z; ang = rq.angle;
    sq = ax * ax + ay * ay + az * az;
    if (sq == 0) begin
      zero_axis_reqs++;
      for (int i = 0; i < 4; i++) begin
        row = '0;
        row.row_index = 2'(i);
        row.elem0 = (i == 0) ? aarm_pkg::Q14_ONE : 16'sd0;
        row.elem1 = (i == 1) ? aarm_pkg::Q14_ONE : 16'sd0;
        row.elem2 = (i == 2) ? aarm_pkg::Q14_ONE : 16'sd0;
        row.elem3 = (i == 3) ? aarm_pkg::Q14_ONE : 16'sd0;
        row.last_row = (i == 3);
        row.axis_error = 1'b1;
        expected_rows.push_back(row);
      end
      return;
    end
    m = 0;
    while (m < 31 && (sq << (2 * (m + 1))) < (64'd1 << 62) &&
           ((sq << (2 * (m + 1))) >> (2 * (m + 1))) == sq) m++;
    root = isqrt(sq << (2 * m));
    ux = unit_q30(ax, m, root);
    uy = unit_q30(ay, m, root);
    uz = unit_q30(az, m, root);
    r = ang % 46080;
    if (r < 0) r += 46080;
    p = (longint'(r) << 32) / 46080;
    flip = 0;
    if (p >= (64'd1 << 30) && p < (64'd3 << 30)) begin
      p = (p + (64'd1 << 31)) & 64'hFFFF_FFFF;
      flip = 1;
    end
    z = longint'(signed'(32'(p)));
    x = K_GAIN;
    y = 0;
    for (int i = 0; i < NSTAGE && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_T[i];
      end else begin
        x += dx; y -= dy; z += ATAN_T[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = ONE_Q30 - c;
    mtx[0][0] = asr(asr(ux * ux, 30) * t, 30) + c;
    mtx[1][1] = asr(asr(uy * uy, 30) * t, 30) + c;
    mtx[2][2] = asr(asr(uz * uz, 30) * t, 30) + c;
    mtx[0][1] = asr(asr(ux * uy, 30) * t, 30) - asr(uz * s, 30);
    mtx[1][0] = asr(asr(ux * uy, 30) * t, 30) + asr(uz * s, 30);
    mtx[0][2] = asr(asr(ux * uz, 30) * t, 30) + asr(uy * s, 30);
    mtx[2][0] = asr(asr(ux * uz, 30) * t, 30) - asr(uy * s, 30);
    mtx[1][2] = asr(asr(uy * uz, 30) * t, 30) - asr(ux * s, 30);
    mtx[2][1] = asr(asr(uy * uz, 30) * t, 30) + asr(ux * s, 30);
    for (int i = 0; i < 3; i++) begin
      row = '0;
      row.row_index = 2'(i);
      row.elem0 = q30_to_q14(mtx[i][0]);
      row.elem1 = q30_to_q14(mtx[i][1]);
      row.elem2 = q30_to_q14(mtx[i][2]);
      expected_rows.push_back(row);
    end
    row = '0;
    row.row_index = aarm_pkg::ROW_LAST;
    row.elem3 = aarm_pkg::Q14_ONE;
    row.last_row = 1'b1;
    expected_rows.push_back(row);
  endtask

  function automatic aarm_pkg::in_t rand_req();
    aarm_pkg::in_t rq;
    int k;
    rq.angle = 24'($urandom);
    k = $urandom_range(0, 9);
    if (k < 6) begin
      rq.axis_x = 16'($urandom); rq.axis_y = 16'($urandom); rq.axis_z = 16'($urandom);
    end else if (k < 9) begin
      // small axes, exercise large normalization shifts
      rq.axis_x = 16'($signed($urandom_range(0, 6)) - 3);
      rq.axis_y = 16'($signed($urandom_range(0, 6)) - 3);
      rq.axis_z = 16'($signed($urandom_range(0, 6)) - 3);
    end else begin
      rq.axis_x = 0; rq.axis_y = 0; rq.axis_z = 0;
    end
    return rq;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_rotation(in_data);
        reqs_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          send_gap <= $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    aarm_pkg::out_t exp_row;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        rows_seen++;
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected row %p", out_data);
        end else begin
          exp_row = expected_rows.pop_front();
          if (exp_row !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("row mismatch: exp %p got %p", exp_row, out_data);
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready)
          recv_gap <= $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
      end
    end
  end

  // long receiver stall so the pipe backs up
  initial begin
    wait (rst_n);
    wait (reqs_sent >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    aarm_pkg::in_t rq;
    int angs[8] = '{0, 8388607, -8388608, 11520, 23040, 34560, -1, 46080};
    int total_reqs;
    for (int i = 0; i < 8; i++) begin
      rq.angle = 24'(angs[i]);
      rq.axis_x = 16'(i); rq.axis_y = 16'(i * 3 - 7); rq.axis_z = 16'(1);
      pending_reqs.push_back(rq);
    end
    rq = '{angle: 24'sd5760, axis_x: 16'sd0, axis_y: 16'sd0, axis_z: 16'sd0};
    pending_reqs.push_back(rq);
    rq = '{angle: -24'sd5760, axis_x: 16'sd0, axis_y: 16'sd0, axis_z: 16'sd0};
    pending_reqs.push_back(rq);
    rq = '{angle: 24'sd1000, axis_x: -16'sd32768, axis_y: -16'sd32768, axis_z: -16'sd32768};
    pending_reqs.push_back(rq);
    rq = '{angle: 24'sd7000, axis_x: 16'sd32767, axis_y: 16'sd32767, axis_z: 16'sd32767};
    pending_reqs.push_back(rq);
    rq = '{angle: 24'sd11520, axis_x: 16'sd1, axis_y: 16'sd0, axis_z: 16'sd0};
    pending_reqs.push_back(rq);
    rq = '{angle: 24'sd23040, axis_x: 16'sd0, axis_y: -16'sd1, axis_z: 16'sd0};
    pending_reqs.push_back(rq);
    rq = '{angle: 24'sd2, axis_x: 16'sd0, axis_y: 16'sd0, axis_z: -16'sd32768};
    pending_reqs.push_back(rq);
    rq = '{angle: -24'sd46081, axis_x: 16'sd32767, axis_y: -16'sd32768, axis_z: 16'sd0};
    pending_reqs.push_back(rq);
    for (int i = 0; i < 112; i++) pending_reqs.push_back(rand_req());
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (reqs_sent == total_reqs);
    wait (expected_rows.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    $display("sent %0d requests (%0d zero axis), checked %0d rows, %0d mismatches",
             reqs_sent, zero_axis_reqs, rows_seen, mismatches);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASS axis_angle_rotation_matrix_top");
    end else begin
      $display("FAIL axis_angle_rotation_matrix_top");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL axis_angle_rotation_matrix_top");
    $finish;
  end

endmodule

`default_nettype wire
